[rtl/pidl_pkg.sv]
// Shared types and codes for the positional insert/delete list.
// Used by the top level, the element store and the port checker; no dependencies.
package pidl_pkg;

   localparam int PIDL_CAPACITY = 16;
   localparam int POS_W         = 8;
   localparam int VALUE_W       = 32;
   localparam int COUNT_W       = 5;

   localparam logic [2:0] ACT_READ   = 3'd0;
   localparam logic [2:0] ACT_FRONT  = 3'd1;
   localparam logic [2:0] ACT_END    = 3'd2;
   localparam logic [2:0] ACT_AT     = 3'd3;
   localparam logic [2:0] ACT_DELETE = 3'd4;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic signed [VALUE_W-1:0] NO_VALUE = '1;

   typedef struct packed {
      logic [2:0]                action;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      logic [1:0]                status;
      logic [COUNT_W-1:0]        element_count;
   } rsp_type;

endpackage

[rtl/pidl_store.sv]
// Element store: one write port, one read port with registered read data.
// Depends on pidl_pkg for the value width and the default depth.
module pidl_store
   import pidl_pkg::*;
#(
   parameter int DEPTH = PIDL_CAPACITY
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic signed [VALUE_W-1:0]             wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic signed [VALUE_W-1:0]             rd_data_ff
);

   logic signed [VALUE_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

[rtl/positional_insert_delete_list.sv]
// Positional insert/delete list: top level with the sequencer and result register.
// Depends on pidl_pkg and pidl_store.
//
// Usage:
//   The request channel (req_valid / req_stall / req_data) carries one action, a
//   position and a value per transfer. The response channel (rsp_valid /
//   rsp_stall / rsp_data) returns exactly one result per request: the value read
//   (or all ones), a status code and the element count after the request.
//   The elements live in a single-port-write, single-port-read store. One index
//   register and one shared increment/decrement-and-compare unit walk the tail
//   of the list, moving one element with a read, then a write.
//   With the response side free, a read passes through the read state to the result
//   state, an insert or delete first walks the tail, and a rejected or full request
//   goes straight to the result state.
//   req_stall is high while a request is in progress, so a new request is taken only
//   after the last one is done. A new request is taken while an earlier response
//   still waits in the output register; it completes once that register drains.
//   When the receiver stalls, the response holds unchanged until transferred.
//   Synchronous active-high reset empties the list and drops any response;
//   the store contents are not cleared, only the length.
module positional_insert_delete_list
   import pidl_pkg::*;
#(
   parameter int CAPACITY = PIDL_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LEN_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic [LEN_W-1:0]          len_ff, len_in;
   logic [LEN_W-1:0]          k_ff, k_in;       // walking slot index
   logic [LEN_W-1:0]          tgt_ff, tgt_in;   // insert slot, or read slot
   logic                      ins_ff, ins_in;   // walk direction: insert vs delete
   logic                      hit_ff, hit_in;   // read inside the list
   logic [1:0]                status_ff, status_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic [CMP_W-1:0]          pos_cmp, len_cmp;
   logic                      pos_lt, pos_le, is_full;
   logic [LEN_W-1:0]          k_step;
   logic                      walk_more;
   logic [LEN_W+COUNT_W-1:0]  len_wide;
   logic                      rsp_free;

   logic                      wr_en, rd_en;
   logic [IDX_W-1:0]          wr_addr, rd_addr;
   logic signed [VALUE_W-1:0] wr_data, rd_data;

   pidl_store #(
      .DEPTH (CAPACITY)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // range checks on the incoming position against the current length
   assign pos_cmp = CMP_W'(req_data.position);
   assign len_cmp = CMP_W'(len_ff);
   assign pos_lt  = pos_cmp < len_cmp;
   assign pos_le  = pos_cmp <= len_cmp;
   assign is_full = len_ff == LEN_W'(CAPACITY);

   // shared step unit: insert walks down toward the target, delete walks up
   assign k_step    = ins_ff ? (k_ff - LEN_W'(1)) : (k_ff + LEN_W'(1));
   assign walk_more = ins_ff ? (k_ff != tgt_ff) : (k_step != len_ff);

   assign len_wide = (LEN_W + COUNT_W)'(len_ff);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // store port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = k_step[IDX_W-1:0];
      wr_en   = 1'b0;
      wr_addr = k_ff[IDX_W-1:0];
      wr_data = rd_data;
      unique case (state_ff)
         S_READ: begin
            rd_en   = 1'b1;
            rd_addr = tgt_ff[IDX_W-1:0];
         end
         S_SHIFT_RD: begin
            if (walk_more) begin
               rd_en = 1'b1;
            end else if (ins_ff) begin
               // walk done: drop the new value into the opened slot
               wr_en   = 1'b1;
               wr_addr = tgt_ff[IDX_W-1:0];
               wr_data = value_ff;
            end
         end
         S_SHIFT_WR: begin
            wr_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      k_in         = k_ff;
      tgt_in       = tgt_ff;
      ins_in       = ins_ff;
      hit_in       = hit_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               value_in  = req_data.item_value;
               hit_in    = 1'b0;
               status_in = ST_DONE;
               state_in  = S_FINISH;
               k_in      = len_ff;
               ins_in    = 1'b1;
               unique case (req_data.action)
                  ACT_READ: begin
                     if (pos_lt) begin
                        hit_in   = 1'b1;
                        tgt_in   = LEN_W'(req_data.position);
                        state_in = S_READ;
                     end else begin
                        status_in = ST_RANGE;
                     end
                  end
                  ACT_FRONT, ACT_END: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        tgt_in   = (req_data.action == ACT_FRONT) ? '0 : len_ff;
                        state_in = S_SHIFT_RD;
                     end
                  end
                  ACT_AT: begin
                     if (!pos_le) begin
                        status_in = ST_RANGE;
                     end else if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        tgt_in   = LEN_W'(req_data.position);
                        state_in = S_SHIFT_RD;
                     end
                  end
                  ACT_DELETE: begin
                     if (pos_lt) begin
                        k_in     = LEN_W'(req_data.position);
                        ins_in   = 1'b0;
                        state_in = S_SHIFT_RD;
                     end else begin
                        status_in = ST_RANGE;
                     end
                  end
                  default: begin
                     status_in = ST_RANGE;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_FINISH;
         end
         S_SHIFT_RD: begin
            if (walk_more) begin
               state_in = S_SHIFT_WR;
            end else begin
               len_in   = ins_ff ? (len_ff + LEN_W'(1)) : (len_ff - LEN_W'(1));
               state_in = S_FINISH;
            end
         end
         S_SHIFT_WR: begin
            k_in     = k_step;
            state_in = S_SHIFT_RD;
         end
         S_FINISH: begin
            // advance only when the output register is free or draining
            if (rsp_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.read_value    = hit_ff ? rd_data : NO_VALUE;
               rsp_data_in.status        = status_ff;
               rsp_data_in.element_count = len_wide[COUNT_W-1:0];
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff        <= k_in;
      tgt_ff      <= tgt_in;
      ins_ff      <= ins_in;
      hit_ff      <= hit_in;
      status_ff   <= status_in;
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[rtl/pidl_checker.sv]
// Port-level checks for the positional insert/delete list, bound to the top level.
// Depends on pidl_pkg and positional_insert_delete_list.
module pidl_checker
   import pidl_pkg::*;
#(
   parameter int CAPACITY = PIDL_CAPACITY
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // reset drops any pending response
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // only a completed read carries data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_DONE) |-> rsp_data.read_value == NO_VALUE)
      else $error("rejected request returned data");

   // a dropped insert reports a full list
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_FULL) |-> rsp_data.element_count == FULL_COUNT)
      else $error("full status with list not full");

endmodule

bind positional_insert_delete_list pidl_checker #(.CAPACITY(CAPACITY)) u_pidl_checker (.*);
